// File: rtl/fdn_pkg.sv
// Shared types and constants of the stereo FDN reverb.
package fdn_pkg;

    localparam int LINES_PER_CHANNEL = 4;
    localparam int NUM_LINES         = 2 * LINES_PER_CHANNEL;
    localparam int LINE_SEL_W        = 3;
    localparam int CFG_DATA_W        = 16;
    localparam int CFG_IDX_W         = 3;
    localparam int GAIN_W            = 16;
    localparam int SCALE_W           = 15;
    localparam int LEN_W             = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WET    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd5;

    localparam logic [GAIN_W-1:0]  RST_DECAY = 16'd55705;
    localparam logic [GAIN_W-1:0]  RST_DAMP  = 16'd22938;
    localparam logic [GAIN_W-1:0]  RST_WET   = 16'd19661;
    localparam logic [SCALE_W-1:0] RST_SCALE = 15'd8192;

    // base line lengths in samples
    localparam logic [11:0] BASE_LEN [LINES_PER_CHANNEL] = '{
        12'd1637, 12'd2053, 12'd2593, 12'd3271
    };

    // right lines: len = floor(floor(p * 1031 / 2^16) / 125)
    localparam logic [10:0] RIGHT_MUL = 11'd1031;
    // ceil(2^28 / 125): y * RIGHT_RECIP >> 28 equals y / 125 for y < 2^21
    localparam logic [21:0] RIGHT_RECIP = 22'd2147484;

    typedef struct packed {
        logic                  vld;
        logic [LINE_SEL_W-1:0] line;
        logic [LEN_W-1:0]      len;
    } t_len_wr;

endpackage

// File: rtl/fdn_dmem.sv
// Single-port delay-line memory with registered read data.
module fdn_dmem #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/fdn_len_unit.sv
// Line length calculator: base * scale, right lines stretched by 1031/1000.
module fdn_len_unit import fdn_pkg::*; #(
    parameter int LINE_DEPTH = 8192
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SCALE_W-1:0] i_scale,
    output logic               o_busy,
    output t_len_wr            o_wr
);

    localparam int PW = 27;
    localparam int YW = 21;
    localparam logic [YW:0] MAX_LEN = (YW+1)'(LINE_DEPTH - 1);

    typedef enum logic [5:0] {
        L_IDLE = 6'b000001,
        L_MUL  = 6'b000010,
        L_LEFT = 6'b000100,
        L_RMUL = 6'b001000,
        L_DIV  = 6'b010000,
        L_OUT  = 6'b100000
    } t_lstate;

    t_lstate               r_state;
    logic [LINE_SEL_W-1:0] r_line;
    logic [PW-1:0]         r_p;
    logic [YW-1:0]         r_y;
    logic [37:0]           w_m;
    logic [42:0]           w_q;
    logic [LEN_W-1:0]      w_len;

    assign w_m = 38'(r_p) * 38'(RIGHT_MUL);
    assign w_q = 43'(r_y) * 43'(RIGHT_RECIP);

    always_comb begin
        if (r_y == '0) begin
            w_len = LEN_W'(1);
        end else if ({1'b0, r_y} > MAX_LEN) begin
            w_len = LEN_W'(LINE_DEPTH - 1);
        end else begin
            w_len = r_y[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_MUL;
            r_line  <= '0;
        end else if (i_start) begin
            r_state <= L_MUL;
            r_line  <= '0;
        end else begin
            case (r_state)
                L_MUL: begin
                    r_p     <= PW'(BASE_LEN[r_line[1:0]]) * PW'(i_scale);
                    r_state <= r_line[2] ? L_RMUL : L_LEFT;
                end
                L_LEFT: begin
                    r_y     <= YW'(r_p >> 13);
                    r_state <= L_OUT;
                end
                L_RMUL: begin
                    r_y     <= w_m[36:16];
                    r_state <= L_DIV;
                end
                L_DIV: begin
                    // divide by 125 through the reciprocal
                    r_y     <= YW'(w_q[42:28]);
                    r_state <= L_OUT;
                end
                L_OUT: begin
                    r_line  <= r_line + 1'b1;
                    r_state <= (r_line == LINE_SEL_W'(NUM_LINES - 1)) ? L_IDLE : L_MUL;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != L_IDLE);
    assign o_wr.vld    = (r_state == L_OUT);
    assign o_wr.line   = r_line;
    assign o_wr.len    = w_len;

endmodule

// File: rtl/stereo_fdn_reverb_core.sv
// Top level of the stereo feedback delay network reverb core.
// Each stereo request runs two four-line feedback delay networks (left, then
// right) whose lines all live in one single-port memory, read and written one
// sample per cycle. Per line the sequencer steps through a read, the damper
// multiply, damper update, decay multiply and accumulate; the output gain then
// takes a multiply and an add, and the Householder write-back writes each line
// of the channel in turn. A stereo result runs both channels, a mono one only
// the left, and bypass skips the networks; requests are handled one at a time,
// and the next one can be taken once the result has moved into the output
// register. A finished result sits in an output register, so the next request
// is accepted while it waits. After reset and after every length_scale write
// the line lengths are recomputed (a reciprocal multiply for each right line)
// and the input stalls meanwhile. Line contents need no clearing pass: a
// per-channel fill mark makes a read of a never written entry return zero.
module stereo_fdn_reverb_core import fdn_pkg::*; #(
    parameter int LINE_DEPTH  = 8192,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [SAMPLE_BITS-1:0] i_right_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int W  = SAMPLE_BITS;
    localparam int AW = $clog2(LINE_DEPTH);
    localparam int MA = AW + LINE_SEL_W;
    localparam int PW = W + 18;     // product width
    localparam int SW = W + 4;      // headroom for sums before saturation
    localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (W - 1)) - 1);
    localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
    localparam logic signed [PW-1:0] HALF16 = PW'(32768);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RD   = 10'b0000000010,
        S_DMUL = 10'b0000000100,
        S_DUPD = 10'b0000001000,
        S_TMUL = 10'b0000010000,
        S_TACC = 10'b0000100000,
        S_OMUL = 10'b0001000000,
        S_OADD = 10'b0010000000,
        S_WR   = 10'b0100000000,
        S_EMIT = 10'b1000000000
    } t_state;

    function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
        logic signed [W-1:0] res;
        if (v > SMAX) begin
            res = SMAX[W-1:0];
        end else if (v < SMIN) begin
            res = SMIN[W-1:0];
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    // configuration registers
    logic               r_en, r_st;
    logic [GAIN_W-1:0]  r_decay, r_coef, r_wet;
    logic [SCALE_W-1:0] r_scale;

    // sequencer and channel state
    t_state              r_state;
    logic                r_ch;
    logic [1:0]          r_i;
    logic [AW-1:0]       r_wi   [2];
    logic                r_wrap [2];
    logic [AW-1:0]       r_len  [NUM_LINES];
    logic signed [W-1:0] r_damp [NUM_LINES];
    logic signed [W-1:0] r_tap  [LINES_PER_CHANNEL];
    logic signed [W+1:0] r_sum;
    logic signed [W-1:0] r_x, r_xr, r_dz;
    logic signed [PW-1:0] r_prod;
    logic                r_rvalid;
    logic signed [W-1:0] r_res_l, r_res_r, r_out_l, r_out_r;
    logic                r_ovalid;

    logic [LINE_SEL_W-1:0] w_ln;
    logic [AW-1:0]         w_len_cur, w_wi_cur, w_rp;
    logic [AW:0]           w_rp_ext;
    logic signed [W-1:0]   w_rd;
    logic signed [W:0]     w_diff;
    logic signed [PW-1:0]  w_rnd;
    logic signed [W-1:0]   w_nd, w_tap, w_wval, w_oval;
    logic signed [W:0]     w_half, w_q4;
    logic                  w_accept, w_out_free, w_scale_wr, w_len_busy;
    logic                  w_mem_we;
    logic [MA-1:0]         w_mem_addr;
    logic [W-1:0]          w_mem_q;
    t_len_wr               w_len_wr;

    assign w_ln      = {r_ch, r_i};
    assign w_len_cur = r_len[w_ln];
    assign w_wi_cur  = r_wi[r_ch];
    // read pointer: write index minus line length, modulo the line depth
    assign w_rp_ext  = (w_wi_cur >= w_len_cur)
                     ? {1'b0, w_wi_cur} - {1'b0, w_len_cur}
                     : {1'b0, w_wi_cur} + (AW+1)'(LINE_DEPTH) - {1'b0, w_len_cur};
    assign w_rp      = w_rp_ext[AW-1:0];

    assign w_rd   = r_rvalid ? $signed(w_mem_q) : '0;
    assign w_diff = (W+1)'(w_rd) - (W+1)'(r_damp[w_ln]);
    assign w_rnd  = (r_prod + HALF16) >>> 16;
    assign w_nd   = sat_w(SW'(r_damp[w_ln]) + SW'($signed(w_rnd[W+1:0])));
    assign w_tap  = w_rnd[W-1:0];
    assign w_half = (W+1)'((r_sum + (W+2)'(1)) >>> 1);
    assign w_q4   = (W+1)'((r_sum + (W+2)'(2)) >>> 2);
    assign w_wval = sat_w(SW'(r_x) + SW'(r_tap[r_i]) - SW'(w_half));
    assign w_oval = sat_w(SW'(r_x) + SW'($signed(w_rnd[W+1:0])));

    assign w_mem_we   = (r_state == S_WR);
    assign w_mem_addr = w_mem_we ? {w_ln, w_wi_cur} : {w_ln, w_rp};

    assign w_scale_wr = i_cfg_we && (i_cfg_idx == CFG_SCALE);
    assign o_stall    = (r_state != S_IDLE) || w_len_busy || w_scale_wr;
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_ovalid || !i_stall;

    fdn_len_unit #(.LINE_DEPTH(LINE_DEPTH)) u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_scale_wr),
        .i_scale (r_scale),
        .o_busy  (w_len_busy),
        .o_wr    (w_len_wr)
    );

    fdn_dmem #(.ADDR_W(MA), .DATA_W(W)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_wval),
        .o_rdata (w_mem_q)
    );

    // configuration and length table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en    <= 1'b0;
            r_st    <= 1'b1;
            r_decay <= RST_DECAY;
            r_coef  <= RST_DAMP;
            r_wet   <= RST_WET;
            r_scale <= RST_SCALE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE: r_en    <= i_cfg_data[0];
                CFG_STEREO: r_st    <= i_cfg_data[0];
                CFG_DECAY:  r_decay <= i_cfg_data;
                CFG_DAMP:   r_coef  <= i_cfg_data;
                CFG_WET:    r_wet   <= i_cfg_data;
                CFG_SCALE:  r_scale <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_len_wr.vld) begin
            r_len[w_len_wr.line] <= w_len_wr.len[AW-1:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ch     <= 1'b0;
            r_i      <= '0;
            r_ovalid <= 1'b0;
            r_rvalid <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                r_wi[c]   <= '0;
                r_wrap[c] <= 1'b0;
            end
            for (int k = 0; k < NUM_LINES; k++) begin
                r_damp[k] <= '0;
            end
        end else begin
            if ((r_state == S_EMIT) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_x  <= i_left_in;
                        r_xr <= i_right_in;
                        if (r_en) begin
                            r_ch    <= 1'b0;
                            r_i     <= '0;
                            r_sum   <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_res_l <= i_left_in;
                            r_res_r <= i_right_in;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_RD: begin
                    // entry never written since reset reads as zero
                    r_rvalid <= r_wrap[r_ch] || (w_len_cur <= w_wi_cur);
                    r_state  <= S_DMUL;
                end
                S_DMUL: begin
                    r_prod  <= PW'(w_diff) * PW'($signed({1'b0, r_coef}));
                    r_state <= S_DUPD;
                end
                S_DUPD: begin
                    r_damp[w_ln] <= w_nd;
                    r_dz         <= w_nd;
                    r_state      <= S_TMUL;
                end
                S_TMUL: begin
                    r_prod  <= PW'(r_dz) * PW'($signed({1'b0, r_decay}));
                    r_state <= S_TACC;
                end
                S_TACC: begin
                    r_tap[r_i] <= w_tap;
                    r_sum      <= r_sum + (W+2)'(w_tap);
                    r_i        <= r_i + 2'd1;
                    r_state    <= (r_i == 2'd3) ? S_OMUL : S_RD;
                end
                S_OMUL: begin
                    r_prod  <= PW'(w_q4) * PW'($signed({1'b0, r_wet}));
                    r_state <= S_OADD;
                end
                S_OADD: begin
                    if (!r_ch) begin
                        r_res_l <= w_oval;
                        r_res_r <= w_oval;   // mono copy, replaced in stereo
                    end else begin
                        r_res_r <= w_oval;
                    end
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_i <= r_i + 2'd1;
                    if (r_i == 2'd3) begin
                        if (w_wi_cur == AW'(LINE_DEPTH - 1)) begin
                            r_wi[r_ch]   <= '0;
                            r_wrap[r_ch] <= 1'b1;
                        end else begin
                            r_wi[r_ch] <= w_wi_cur + AW'(1);
                        end
                        if (!r_ch && r_st) begin
                            r_ch    <= 1'b1;
                            r_sum   <= '0;
                            r_x     <= r_xr;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && w_out_free) begin
            r_out_l <= r_res_l;
            r_out_r <= r_res_r;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_left_out  = r_out_l;
    assign o_right_out = r_out_r;

endmodule

// File: rtl/fdn_checker.sv
// Port-level checker of the reverb core and its bind.
module fdn_checker import fdn_pkg::*; #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic signed [SAMPLE_BITS-1:0] i_left_in,
    input logic signed [SAMPLE_BITS-1:0] i_right_in,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic signed [SAMPLE_BITS-1:0] o_left_out,
    input logic signed [SAMPLE_BITS-1:0] o_right_out,
    input logic                          i_cfg_we,
    input logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input logic [CFG_DATA_W-1:0]         i_cfg_data
);

    logic r_en, r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
            r_st <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ENABLE) begin
                r_en <= i_cfg_data[0];
            end
            if (i_cfg_idx == CFG_STEREO) begin
                r_st <= i_cfg_data[0];
            end
        end
    end

    // a held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_left_out) && $stable(o_right_out))
        else $error("output changed while stalled");

    // after an accepted request the core stalls, so the next one must wait
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request accepted back to back");

    // mono reverb copies left to right
    a_mono_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_en && !r_st |-> o_left_out == o_right_out)
        else $error("mono output channels differ");

    // a length_scale write holds off requests in the same cycle
    a_scale_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_idx == CFG_SCALE) |-> o_stall)
        else $error("request taken during length update");

endmodule

bind stereo_fdn_reverb_core fdn_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_fdn_checker (.*);
